@@ sv/cau_pkg.sv @@
// Shared types, codes and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

   // Width of one operand or result part, in bits.
   localparam int WORD_BITS = 32;
   // Default fraction bits of the fixed-point format.
   localparam int FRAC_BITS = 16;
   // Entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   // Clock edges from the edge that accepts a request to the edge that accepts its result.
   localparam int LATENCY = WORD_BITS + 6;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                    kind;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_re;
      logic signed [WORD_BITS-1:0] out_im;
      status_type                  status;
   } rsp_type;

   // A request after classification in the front.
   typedef struct packed {
      req_type req;
      logic    div_zero;
   } item_type;

   // What travels alongside the divider pipeline.
   typedef struct packed {
      rsp_type early;
      logic    is_div;
      logic    neg_re;
      logic    neg_im;
      logic    ovf_re;
      logic    ovf_im;
   } div_side_type;

endpackage
`default_nettype wire

@@ sv/cau_front.sv @@
// Front end: accepts requests and classifies them for the back end.
`default_nettype none
module cau_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire cau_pkg::req_type   req_data,
   input  wire logic               queue_almost_full,
   output logic                    busy,
   output logic                    push,
   output cau_pkg::item_type       push_item
);

   logic              valid_ff;
   logic              valid_in;
   cau_pkg::item_type item_ff;

   assign busy     = reset || queue_almost_full;
   assign valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff.req      <= req_data;
      item_ff.div_zero <= (req_data.kind == cau_pkg::KIND_DIV) &&
                          (req_data.b_re == '0) && (req_data.b_im == '0);
   end

   assign push      = valid_ff;
   assign push_item = item_ff;

endmodule
`default_nettype wire

@@ sv/cau_queue.sv @@
// Short queue of classified requests between the front and the back.
`default_nettype none
module cau_queue #(
   parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cau_pkg::item_type push_item,
   output logic                   almost_full,
   output logic                   pop_valid,
   output cau_pkg::item_type      pop_item
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cau_pkg::item_type   mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign pop_valid   = (count_ff != '0);
   assign pop_item    = mem_ff[rd_ptr_ff];
   assign almost_full = (count_ff >= CNT_BITS'(DEPTH - 1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_valid) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_valid) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ sv/cau_div.sv @@
// Pipelined restoring divider: one quotient bit per stage for both result parts.
`default_nettype none
module cau_div (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic [2*cau_pkg::WORD_BITS-1:0]         in_rem_re,
   input  wire logic [2*cau_pkg::WORD_BITS-1:0]         in_rem_im,
   input  wire logic [cau_pkg::WORD_BITS-1:0]           in_low_re,
   input  wire logic [cau_pkg::WORD_BITS-1:0]           in_low_im,
   input  wire logic [2*cau_pkg::WORD_BITS-1:0]         in_den,
   input  wire cau_pkg::div_side_type                   in_side,
   output logic                                        out_valid,
   output logic [cau_pkg::WORD_BITS-1:0]                out_q_re,
   output logic [cau_pkg::WORD_BITS-1:0]                out_q_im,
   output cau_pkg::div_side_type                        out_side
);

   localparam int W = cau_pkg::WORD_BITS;

   logic                  vld_ff  [1:W];
   logic [2*W-1:0]        rre_ff  [1:W];
   logic [2*W-1:0]        rim_ff  [1:W];
   logic [W-1:0]          lre_ff  [1:W];
   logic [W-1:0]          lim_ff  [1:W];
   logic [W-1:0]          qre_ff  [1:W];
   logic [W-1:0]          qim_ff  [1:W];
   logic [2*W-1:0]        den_ff  [1:W];
   cau_pkg::div_side_type side_ff [1:W];

   for (genvar s = 0; s < W; s++) begin : g_stage
      logic                  vld;
      logic [2*W-1:0]        rre, rim, den;
      logic [W-1:0]          lre, lim, qre, qim;
      cau_pkg::div_side_type side;
      logic [2*W:0]          tre, tim, dre, dim;
      logic                  bre, bim;

      if (s == 0) begin : g_first
         assign vld  = in_valid;
         assign rre  = in_rem_re;
         assign rim  = in_rem_im;
         assign lre  = in_low_re;
         assign lim  = in_low_im;
         assign qre  = '0;
         assign qim  = '0;
         assign den  = in_den;
         assign side = in_side;
      end else begin : g_next
         assign vld  = vld_ff[s];
         assign rre  = rre_ff[s];
         assign rim  = rim_ff[s];
         assign lre  = lre_ff[s];
         assign lim  = lim_ff[s];
         assign qre  = qre_ff[s];
         assign qim  = qim_ff[s];
         assign den  = den_ff[s];
         assign side = side_ff[s];
      end

      // Bring down the next numerator bit, then try to subtract the divisor.
      assign tre = {rre, lre[W-1]};
      assign tim = {rim, lim[W-1]};
      assign dre = tre - {1'b0, den};
      assign dim = tim - {1'b0, den};
      assign bre = (tre >= {1'b0, den});
      assign bim = (tim >= {1'b0, den});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld;
         end
         rre_ff[s+1]  <= bre ? dre[2*W-1:0] : tre[2*W-1:0];
         rim_ff[s+1]  <= bim ? dim[2*W-1:0] : tim[2*W-1:0];
         lre_ff[s+1]  <= {lre[W-2:0], 1'b0};
         lim_ff[s+1]  <= {lim[W-2:0], 1'b0};
         qre_ff[s+1]  <= {qre[W-2:0], bre};
         qim_ff[s+1]  <= {qim[W-2:0], bim};
         den_ff[s+1]  <= den;
         side_ff[s+1] <= side;
      end
   end

   assign out_valid = vld_ff[W];
   assign out_q_re  = qre_ff[W];
   assign out_q_im  = qim_ff[W];
   assign out_side  = side_ff[W];

endmodule
`default_nettype wire

@@ sv/cau_back.sv @@
// Back end: multipliers, sums, divider setup, divider and saturation.
`default_nettype none
module cau_back #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire cau_pkg::item_type in_item,
   output logic                   out_valid,
   output cau_pkg::rsp_type       out_rsp
);

   localparam int W        = cau_pkg::WORD_BITS;
   localparam int NUM_BITS = 2 * W + FRAC_BITS;
   localparam int CMP_BITS = (W + FRAC_BITS > 2 * W) ? W + FRAC_BITS : 2 * W;

   // Returns {overflow, value} of v clamped to a signed word.
   function automatic logic [W:0] sat_word(input logic signed [2*W:0] v);
      logic         ovf;
      logic [W-1:0] res;
      ovf = (v[2*W:W-1] != {(W+2){v[2*W]}});
      if (!ovf) begin
         res = v[W-1:0];
      end else if (v[2*W]) begin
         res = {1'b1, {(W-1){1'b0}}};
      end else begin
         res = {1'b0, {(W-1){1'b1}}};
      end
      return {ovf, res};
   endfunction

   // Applies the sign to a quotient magnitude and clamps it; returns {overflow, value}.
   function automatic logic [W:0] div_final(input logic [W-1:0] q, input logic neg,
                                            input logic big);
      logic         ovf;
      logic [W-1:0] res;
      if (neg) begin
         ovf = big || (q > {1'b1, {(W-1){1'b0}}});
         res = ovf ? {1'b1, {(W-1){1'b0}}} : (~q + 1'b1);
      end else begin
         ovf = big || q[W-1];
         res = ovf ? {1'b0, {(W-1){1'b1}}} : q;
      end
      return {ovf, res};
   endfunction

   // Stage 1: products and the add or subtract result.
   logic                   v1_ff;
   cau_pkg::kind_type      kind1_ff;
   logic                   dz1_ff;
   logic signed [2*W-1:0]  pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [W:0]      asre1_ff, asim1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      kind1_ff <= in_item.req.kind;
      dz1_ff   <= in_item.div_zero;
      pa_ff    <= in_item.req.a_re * in_item.req.b_re;
      pb_ff    <= in_item.req.a_im * in_item.req.b_im;
      pc_ff    <= in_item.req.a_re * in_item.req.b_im;
      pd_ff    <= in_item.req.a_im * in_item.req.b_re;
      pe_ff    <= in_item.req.b_re * in_item.req.b_re;
      pf_ff    <= in_item.req.b_im * in_item.req.b_im;
      if (in_item.req.kind == cau_pkg::KIND_SUB) begin
         asre1_ff <= in_item.req.a_re - in_item.req.b_re;
         asim1_ff <= in_item.req.a_im - in_item.req.b_im;
      end else begin
         asre1_ff <= in_item.req.a_re + in_item.req.b_re;
         asim1_ff <= in_item.req.a_im + in_item.req.b_im;
      end
   end

   // Stage 2: cross sums and the squared magnitude of b.
   logic                   v2_ff;
   cau_pkg::kind_type      kind2_ff;
   logic                   dz2_ff;
   logic signed [W:0]      asre2_ff, asim2_ff;
   logic signed [2*W:0]    sre2_ff, sim2_ff;
   logic [2*W-1:0]         den2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      kind2_ff <= kind1_ff;
      dz2_ff   <= dz1_ff;
      asre2_ff <= asre1_ff;
      asim2_ff <= asim1_ff;
      if (kind1_ff == cau_pkg::KIND_MUL) begin
         sre2_ff <= pa_ff - pb_ff;
         sim2_ff <= pc_ff + pd_ff;
      end else begin
         sre2_ff <= pa_ff + pb_ff;
         sim2_ff <= pd_ff - pc_ff;
      end
      den2_ff <= $unsigned(pe_ff) + $unsigned(pf_ff);
   end

   // Stage 3: finish add, subtract and multiply; prepare the division.
   logic signed [2*W:0]   mre_sh, mim_sh, nre_full, nim_full;
   logic [2*W-1:0]        mag_re, mag_im;
   logic [NUM_BITS-1:0]   num_re, num_im;
   logic [W+FRAC_BITS-1:0] hi_re, hi_im;
   logic [W:0]            sat_re, sat_im;
   cau_pkg::div_side_type side3_in;

   always_comb begin
      mre_sh   = sre2_ff >>> FRAC_BITS;
      mim_sh   = sim2_ff >>> FRAC_BITS;
      nre_full = -sre2_ff;
      nim_full = -sim2_ff;
      mag_re   = sre2_ff[2*W] ? nre_full[2*W-1:0] : sre2_ff[2*W-1:0];
      mag_im   = sim2_ff[2*W] ? nim_full[2*W-1:0] : sim2_ff[2*W-1:0];
      num_re   = NUM_BITS'(mag_re) << FRAC_BITS;
      num_im   = NUM_BITS'(mag_im) << FRAC_BITS;
      hi_re    = num_re[NUM_BITS-1:W];
      hi_im    = num_im[NUM_BITS-1:W];

      if (kind2_ff == cau_pkg::KIND_MUL) begin
         sat_re = sat_word(mre_sh);
         sat_im = sat_word(mim_sh);
      end else begin
         sat_re = sat_word((2*W+1)'(asre2_ff));
         sat_im = sat_word((2*W+1)'(asim2_ff));
      end

      side3_in.early.out_re = sat_re[W-1:0];
      side3_in.early.out_im = sat_im[W-1:0];
      side3_in.early.status = (sat_re[W] || sat_im[W]) ?
                              cau_pkg::STATUS_OVERFLOW : cau_pkg::STATUS_OK;
      if (dz2_ff) begin
         side3_in.early.out_re = '0;
         side3_in.early.out_im = '0;
         side3_in.early.status = cau_pkg::STATUS_DIV_ZERO;
      end
      side3_in.is_div = (kind2_ff == cau_pkg::KIND_DIV) && !dz2_ff;
      side3_in.neg_re = sre2_ff[2*W];
      side3_in.neg_im = sim2_ff[2*W];
      // A quotient of 2^W or more shows as the numerator's upper part reaching the divisor.
      side3_in.ovf_re = (CMP_BITS'(hi_re) >= CMP_BITS'(den2_ff));
      side3_in.ovf_im = (CMP_BITS'(hi_im) >= CMP_BITS'(den2_ff));
   end

   logic                  v3_ff;
   logic [2*W-1:0]        rre3_ff, rim3_ff, den3_ff;
   logic [W-1:0]          lre3_ff, lim3_ff;
   cau_pkg::div_side_type side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      rre3_ff  <= (2*W)'(hi_re);
      rim3_ff  <= (2*W)'(hi_im);
      lre3_ff  <= num_re[W-1:0];
      lim3_ff  <= num_im[W-1:0];
      den3_ff  <= den2_ff;
      side3_ff <= side3_in;
   end

   logic                  dv_valid;
   logic [W-1:0]          q_re, q_im;
   cau_pkg::div_side_type dv_side;

   cau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_rem_re (rre3_ff),
      .in_rem_im (rim3_ff),
      .in_low_re (lre3_ff),
      .in_low_im (lim3_ff),
      .in_den    (den3_ff),
      .in_side   (side3_ff),
      .out_valid (dv_valid),
      .out_q_re  (q_re),
      .out_q_im  (q_im),
      .out_side  (dv_side)
   );

   // Output stage: sign and clamp the quotients, or pass on the early result of the other kinds.
   logic [W:0]       fin_re, fin_im;
   cau_pkg::rsp_type rsp_in;
   logic             valid_ff;
   cau_pkg::rsp_type rsp_ff;

   always_comb begin
      fin_re = div_final(q_re, dv_side.neg_re, dv_side.ovf_re);
      fin_im = div_final(q_im, dv_side.neg_im, dv_side.ovf_im);
      if (dv_side.is_div) begin
         rsp_in.out_re = fin_re[W-1:0];
         rsp_in.out_im = fin_im[W-1:0];
         rsp_in.status = (fin_re[W] || fin_im[W]) ?
                         cau_pkg::STATUS_OVERFLOW : cau_pkg::STATUS_OK;
      end else begin
         rsp_in = dv_side.early;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dv_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

@@ sv/complex_arith_unit_core.sv @@
// Top level of the complex arithmetic unit: front end, request queue and back end.
`default_nettype none
// Complex ALU on two signed fixed-point operands a and b, each part WORD_BITS wide with
// FRAC_BITS fraction bits (Q16.16 by default). A request is taken at a rising edge where
// start is high and busy is low; kind selects add, subtract, multiply or divide a by b.
// Every request produces exactly one response, shown on rsp_data for a single cycle while
// rsp_valid is high; the receiver cannot stall it, so it must take the response then.
// The unit is fully pipelined and accepts one request per clock. Every kind takes the same
// path, so responses leave in request order. A request passes the front register, the queue,
// the back stages, the divider stages and the output register before its response appears.
// The divider resolves one quotient bit per pipeline stage, and add, subtract and multiply
// ride along with it. busy is high during reset and otherwise only if the internal request
// queue nears full, which does not happen in normal flow. Products are exact and shifted
// right arithmetically (rounding toward minus infinity); quotients truncate toward zero. A
// part that does not fit is clamped and the status reads overflow; dividing by zero returns
// zero parts and a division-by-zero status.
module complex_arith_unit_core #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cau_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cau_pkg::rsp_type      rsp_data
);

   // The front registers each request and flags a divide by zero up front.
   logic              push;
   cau_pkg::item_type push_item;
   logic              almost_full;

   cau_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_data          (req_data),
      .queue_almost_full (almost_full),
      .busy              (busy),
      .push              (push),
      .push_item         (push_item)
   );

   // The queue decouples the front from the back; the back drains it every cycle.
   logic              pop_valid;
   cau_pkg::item_type pop_item;

   cau_queue #(
      .DEPTH (cau_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_item   (push_item),
      .almost_full (almost_full),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item)
   );

   // The back computes the result and drives the registered response outputs.
   cau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_item   (pop_item),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule
`default_nettype wire

@@ sv/cau_checker.sv @@
// Port-level checks of the complex arithmetic unit, bound to its top level.
`default_nettype none
module cau_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire cau_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire cau_pkg::rsp_type rsp_data
);

   localparam int W        = cau_pkg::WORD_BITS;
   localparam int LAT      = cau_pkg::LATENCY;
   localparam int CNT_BITS = $clog2(LAT + 1);

   logic                accept;
   logic                div_zero_req;
   logic [CNT_BITS-1:0] warm_ff;
   logic                warm;

   assign accept       = start && !busy;
   assign div_zero_req = accept && (req_data.kind == cau_pkg::KIND_DIV) &&
                         (req_data.b_re == '0) && (req_data.b_im == '0);
   assign warm         = (warm_ff == CNT_BITS'(LAT));

   // Counts clean cycles since reset so that checks look back only over them.
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else if (!warm) begin
         warm_ff <= warm_ff + 1'b1;
      end
   end

   a_one_response_per_request: assert property (@(posedge clock) disable iff (reset)
      warm |-> (rsp_valid == $past(accept, LAT)))
      else $error("response strobe does not match an accepted request");

   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      (warm && $past(div_zero_req, LAT)) |->
         (rsp_valid && rsp_data.out_re == '0 && rsp_data.out_im == '0 &&
          rsp_data.status == cau_pkg::STATUS_DIV_ZERO))
      else $error("division by zero did not give zeros with its status");

   a_div_zero_only_from_div: assert property (@(posedge clock) disable iff (reset)
      (warm && rsp_valid && rsp_data.status == cau_pkg::STATUS_DIV_ZERO) |->
         $past(div_zero_req, LAT))
      else $error("division-by-zero status without a divide by zero");

   a_overflow_clamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == cau_pkg::STATUS_OVERFLOW) |->
         (rsp_data.out_re == {1'b1, {(W-1){1'b0}}} ||
          rsp_data.out_re == {1'b0, {(W-1){1'b1}}} ||
          rsp_data.out_im == {1'b1, {(W-1){1'b0}}} ||
          rsp_data.out_im == {1'b0, {(W-1){1'b1}}}))
      else $error("overflow status without a clamped part");

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
